// ===== rtl/rain_gauge_window_accumulator_assert.svh =====
// Assertion helpers used by the rain gauge accumulator RTL.
`ifndef RAIN_GAUGE_WINDOW_ACCUMULATOR_ASSERT_SVH
`define RAIN_GAUGE_WINDOW_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RGWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgwa check failed");

// Next-cycle implication, checked out of reset.
`define RGWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgwa check failed");

`endif

// ===== rtl/rgwa_pkg.sv =====
package rgwa_pkg;

    // Default window geometry
    localparam int BINS_PER_HOUR_DEF = 12;
    localparam int WINDOW_HOURS_DEF  = 24;

    // Field widths
    localparam int BIN_W    = 16;
    localparam int NBINS_W  = 9;
    localparam int SUM_W    = 25;
    localparam int RAIN_W   = 57;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W  = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_PRESCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UM_PER_TIP     = 2'd1;

    localparam logic [CFG_W-1:0] PULSE_PRESCALE_RST = 16'd1;
    localparam logic [CFG_W-1:0] UM_PER_TIP_RST     = 16'd200;

    typedef enum logic [1:0] {
        CMD_PULSE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PULSE_WR,
        ST_SUM,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [NBINS_W-1:0] window_bins;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0]  bin_sum;
        logic [RAIN_W-1:0] rainfall_um;
        logic              window_error;
    } t_out_item;

endpackage

// ===== rtl/rgwa_bin_ram.sv =====
module rgwa_bin_ram #(
    parameter int DEPTH = 288,
    parameter int AW    = 9
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [rgwa_pkg::BIN_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [rgwa_pkg::BIN_W-1:0] o_rdata
);
    import rgwa_pkg::*;

    logic [BIN_W-1:0] r_mem [DEPTH];
    logic [BIN_W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rgwa_mul.sv =====
module rgwa_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rgwa_pkg::MUL_A_W-1:0] i_a,
    input  logic [rgwa_pkg::SUM_W-1:0]   i_b,
    output logic [rgwa_pkg::RAIN_W-1:0]  o_p
);
    import rgwa_pkg::*;

    logic [RAIN_W-1:0] r_p;

    // 32x25 product, registered; reused for both scaling steps
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= RAIN_W'(i_a) * RAIN_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/rain_gauge_window_accumulator.sv =====
// Rain gauge window accumulator.
// Input channel (i_in_valid/o_in_ready, i_in_data): one command per beat.
//   Gauge pulse: steps the prescaler, and when it wraps adds a bin read-modify-write.
//   Tick: ages the circular bin store and zeroes the new bin.
//   Query: unless the window is oversize, the bin walk reads one bin per cycle
//   from the single read port of the bin RAM, then the shared multiplier
//   runs twice (prescale*um, then sum*that).
//   Clear: zeroes all DEPTH bins, one per cycle.
// The block takes the next command only once the current one is done.
// Output channel (o_out_valid/i_out_ready, o_out_data): one beat per query,
//   held in an output register; a new command is accepted while it waits,
//   and a second query result waits in the sequencer until the first is taken.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) is
//   always ready; write it only while the block is idle.
// Reset (synchronous, active low) runs the same clearing pass as a clear
//   command, zeroing all DEPTH bins (288 by default) before o_in_ready rises.
`include "rain_gauge_window_accumulator_assert.svh"

module rain_gauge_window_accumulator #(
    parameter int BINS_PER_HOUR = rgwa_pkg::BINS_PER_HOUR_DEF,
    parameter int WINDOW_HOURS  = rgwa_pkg::WINDOW_HOURS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rgwa_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rgwa_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rgwa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgwa_pkg::CFG_W-1:0]     i_cfg_data
);
    import rgwa_pkg::*;

    localparam int DEPTH = BINS_PER_HOUR * WINDOW_HOURS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_prescale, r_um;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [BIN_W-1:0]   r_pcount, n_pcount;
    logic [AW-1:0]      r_addr, n_addr;
    logic [NBINS_W-1:0] r_cnt, n_cnt;
    logic               r_rd_vld, n_rd_vld;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_err, n_err;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out_data, n_out_data;

    logic               in_acc;
    logic               out_free;
    logic               too_wide;
    logic [BIN_W:0]     pcount_inc;
    logic [AW-1:0]      ptr_inc;
    logic [AW-1:0]      addr_dec;
    logic [SUM_W:0]     sum_add;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [BIN_W-1:0]   ram_wdata, ram_rdata;

    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [SUM_W-1:0]   mul_b;
    logic [RAIN_W-1:0]  mul_p;

    rgwa_bin_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rgwa_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Handshake and shared helpers
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign too_wide    = 32'(i_in_data.window_bins) > 32'(DEPTH);
    assign pcount_inc  = {1'b0, r_pcount} + 17'd1;
    assign ptr_inc     = (r_ptr == LAST_ADDR) ? '0 : r_ptr + AW'(1);
    assign addr_dec    = (r_addr == '0) ? LAST_ADDR : r_addr - AW'(1);
    assign sum_add     = {1'b0, r_sum} + (SUM_W + 1)'(ram_rdata);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.command)
                        CMD_PULSE: begin
                            if (pcount_inc >= {1'b0, r_prescale}) n_state = ST_PULSE_WR;
                        end
                        CMD_TICK:  n_state = ST_IDLE;
                        CMD_QUERY: n_state = too_wide ? ST_MUL1 : ST_SUM;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PULSE_WR: n_state = ST_IDLE;
            ST_SUM: begin
                if (r_cnt == '0 && !r_rd_vld) n_state = ST_MUL1;
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath controls and register next values
    always_comb begin
        n_ptr      = r_ptr;
        n_clr_addr = r_clr_addr;
        n_pcount   = r_pcount;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_rd_vld   = 1'b0;
        n_sum      = r_sum;
        n_err      = r_err;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_data = r_out_data;
        ram_we     = 1'b0;
        ram_waddr  = r_ptr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_ptr;
        mul_en     = 1'b0;
        mul_a      = MUL_A_W'(r_prescale);
        mul_b      = SUM_W'(r_um);
        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.command)
                        CMD_PULSE: begin
                            // prescaler wrap: fetch the newest bin for increment
                            if (pcount_inc >= {1'b0, r_prescale}) begin
                                ram_re   = 1'b1;
                                n_pcount = '0;
                            end else begin
                                n_pcount = pcount_inc[BIN_W-1:0];
                            end
                        end
                        CMD_TICK: begin
                            n_ptr     = ptr_inc;
                            ram_we    = 1'b1;
                            ram_waddr = ptr_inc;
                        end
                        CMD_QUERY: begin
                            n_err  = too_wide;
                            n_sum  = '0;
                            n_cnt  = too_wide ? '0 : i_in_data.window_bins;
                            n_addr = r_ptr;
                        end
                        CMD_CLEAR: begin
                            n_clr_addr = '0;
                            n_ptr      = '0;
                            n_pcount   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PULSE_WR: begin
                ram_we    = 1'b1;
                ram_wdata = (ram_rdata == BIN_MAX) ? ram_rdata : ram_rdata + BIN_W'(1);
            end
            ST_SUM: begin
                // issue one read per cycle, accumulate the one returning
                if (r_cnt != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr;
                    n_addr    = addr_dec;
                    n_cnt     = r_cnt - NBINS_W'(1);
                    n_rd_vld  = 1'b1;
                end
                if (r_rd_vld) begin
                    n_sum = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                end
            end
            ST_MUL1: begin
                mul_en = 1'b1;
            end
            ST_MUL2: begin
                // prescale*um fits 32 bits
                mul_en = 1'b1;
                mul_a  = mul_p[MUL_A_W-1:0];
                mul_b  = r_sum;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld               = 1'b1;
                    n_out_data.bin_sum      = r_sum;
                    n_out_data.rainfall_um  = mul_p;
                    n_out_data.window_error = r_err;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ptr      <= '0;
            r_pcount   <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_prescale <= PULSE_PRESCALE_RST;
            r_um       <= UM_PER_TIP_RST;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ptr      <= n_ptr;
            r_pcount   <= n_pcount;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PULSE_PRESCALE: r_prescale <= i_cfg_data;
                    REG_UM_PER_TIP:     r_um       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_sum      <= n_sum;
        r_err      <= n_err;
        r_out_data <= n_out_data;
    end

    `RGWA_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1, 32'(r_ptr) < 32'(DEPTH))
    `RGWA_ASSERT_NOW(a_rd_in_sum, i_clk, i_rst_n, r_rd_vld, r_state == ST_SUM)
    `RGWA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.window_error,
        o_out_data.bin_sum == '0 && o_out_data.rainfall_um == '0)
    `RGWA_ASSERT_NEXT(a_query_walk, i_clk, i_rst_n,
        in_acc && i_in_data.command == CMD_QUERY,
        r_state == ST_SUM || r_state == ST_MUL1)

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgwa_pkg::*;

    localparam int unsigned BIN_COUNT      = BINS_PER_HOUR_DEF * WINDOW_HOURS_DEF;
    localparam int unsigned SETTLE_CYCLES  = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned FILL_PULSES    = 65540;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        t_in_item  item;
        bit        pinned;
        t_out_item want;
    } t_dir_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predictor state
    bit [BIN_W-1:0] bin_cnt [BIN_COUNT];
    int unsigned    newest_ptr     = 0;
    bit [BIN_W-1:0] prescale_cnt   = '0;
    bit [CFG_W-1:0] cfg_prescale   = PULSE_PRESCALE_RST;
    bit [CFG_W-1:0] cfg_um_per_tip = UM_PER_TIP_RST;

    t_out_item   query_results_q [$];
    t_out_item   oldest_want;
    int unsigned err_cnt     = 0;
    int unsigned stall_left  = 0;
    int unsigned quiet_count = 0;
    bit          gap_on      = 1'b1;
    bit          stall_on    = 1'b1;
    bit          spare_flip  = 1'b0;
    t_dir_row    dir_rows [24];

    rain_gauge_window_accumulator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Window accumulator prediction: updates the bins, returns 1 when a result is due
    function automatic bit gauge_step(input t_in_item it, output t_out_item res);
        logic [16:0] next_cnt;
        logic [31:0] total;
        logic [63:0] product;
        int unsigned slot;
        res = '0;
        case (it.command)
            CMD_PULSE: begin
                next_cnt = {1'b0, prescale_cnt} + 17'd1;
                if (next_cnt >= {1'b0, cfg_prescale}) begin
                    if (bin_cnt[newest_ptr] != BIN_MAX)
                        bin_cnt[newest_ptr] = bin_cnt[newest_ptr] + 1'b1;
                    prescale_cnt = '0;
                end else begin
                    prescale_cnt = next_cnt[BIN_W-1:0];
                end
                return 1'b0;
            end
            CMD_TICK: begin
                newest_ptr = (newest_ptr + 1) % BIN_COUNT;
                bin_cnt[newest_ptr] = '0;
                return 1'b0;
            end
            CMD_QUERY: begin
                if (it.window_bins > BIN_COUNT) begin
                    res.window_error = 1'b1;
                    return 1'b1;
                end
                total = '0;
                for (int unsigned i = 0; i < it.window_bins; i++) begin
                    slot  = (newest_ptr + BIN_COUNT - i) % BIN_COUNT;
                    total = total + bin_cnt[slot];
                end
                if (total > SUM_MAX)
                    total = SUM_MAX;
                product = 64'(total) * 64'(cfg_prescale) * 64'(cfg_um_per_tip);
                res.bin_sum     = total[SUM_W-1:0];
                res.rainfall_um = product[RAIN_W-1:0];
                return 1'b1;
            end
            default: begin
                foreach (bin_cnt[i])
                    bin_cnt[i] = '0;
                newest_ptr   = 0;
                prescale_cnt = '0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic t_dir_row dir_row(input t_cmd cmd, input int unsigned n,
                                         input bit pinned = 1'b0,
                                         input int unsigned sum = 0,
                                         input longint unsigned rain = 0,
                                         input bit err = 1'b0);
        t_dir_row r;
        r.item.command          = cmd;
        r.item.window_bins      = NBINS_W'(n);
        r.pinned                = pinned;
        r.want.bin_sum          = SUM_W'(sum);
        r.want.rainfall_um      = RAIN_W'(rain);
        r.want.window_error     = err;
        return r;
    endfunction

    // Mostly pulses and ticks to build up bins, queries of all window sizes, rare clears
    function automatic t_in_item rand_cmd();
        t_in_item    it;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        it.window_bins = NBINS_W'($urandom);
        if (pick < 55) begin
            it.command = CMD_PULSE;
        end else if (pick < 76) begin
            it.command = CMD_TICK;
        end else if (pick < 98) begin
            it.command = CMD_QUERY;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                it.window_bins = '0;
            else if (pick < 3)
                it.window_bins = NBINS_W'(BIN_COUNT);
            else if (pick < 5)
                it.window_bins = NBINS_W'($urandom_range(BIN_COUNT + 1, 511));
            else if (pick < 12)
                it.window_bins = NBINS_W'($urandom_range(1, 24));
            else
                it.window_bins = NBINS_W'($urandom_range(1, BIN_COUNT - 1));
        end else begin
            it.command = CMD_CLEAR;
        end
        return it;
    endfunction

    // One command beat; a pinned result replaces the predicted one
    task automatic send_cmd(input t_in_item it, input bit pinned = 1'b0,
                            input t_out_item pinned_res = '0);
        t_out_item res;
        if (gap_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (gauge_step(it, res))
            query_results_q.push_back(pinned ? pinned_res : res);
        @(negedge clk);
    endtask

    task automatic send_plain(input t_cmd cmd, input int unsigned n);
        t_in_item it;
        it.command     = cmd;
        it.window_bins = NBINS_W'(n);
        send_cmd(it);
    endtask

    // Hold off until every query result is back, then let a clear finish
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (query_results_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Spare index first (must be ignored), then both real registers
    task automatic write_regs(input logic [CFG_W-1:0] prescale, input logic [CFG_W-1:0] um);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_W-1:0]     val [3];
        idx[0] = spare_flip ? REG_SPARE_B : REG_SPARE_A;
        val[0] = CFG_W'($urandom);
        idx[1] = REG_PULSE_PRESCALE;
        val[1] = prescale;
        idx[2] = REG_UM_PER_TIP;
        val[2] = um;
        spare_flip = !spare_flip;
        for (int w = 0; w < 3; w++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[w];
            cfg_data  <= val[w];
            do @(posedge clk); while (!cfg_ready);
            if (idx[w] == REG_PULSE_PRESCALE)
                cfg_prescale = val[w];
            else if (idx[w] == REG_UM_PER_TIP)
                cfg_um_per_tip = val[w];
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input logic [CFG_W-1:0] prescale, input logic [CFG_W-1:0] um,
                              input int unsigned count, input bit idling);
        drain_and_settle();
        write_regs(prescale, um);
        gap_on   = idling;
        stall_on = idling;
        repeat (count)
            send_cmd(rand_cmd());
    endtask

    // Fill one bin to saturation, read it back at extreme registers, then age it out
    task automatic run_saturation();
        t_in_item it;
        drain_and_settle();
        write_regs('0, UM_PER_TIP_RST);
        gap_on   = 1'b0;
        stall_on = 1'b0;
        it.command = CMD_PULSE;
        repeat (FILL_PULSES) begin
            it.window_bins = NBINS_W'($urandom);
            send_cmd(it);
        end
        send_plain(CMD_QUERY, 1);
        send_plain(CMD_QUERY, BIN_COUNT);
        drain_and_settle();
        write_regs('1, '1);
        gap_on   = 1'b1;
        stall_on = 1'b1;
        send_plain(CMD_QUERY, BIN_COUNT);
        send_plain(CMD_QUERY, 1);
        send_plain(CMD_QUERY, BIN_COUNT + 1);
        // walk the pointer all the way round
        for (int t = 0; t < BIN_COUNT + 12; t++) begin
            send_plain(CMD_TICK, $urandom);
            if (t % 24 == 0)
                send_plain(CMD_QUERY, BIN_COUNT);
        end
    endtask

    // Result side: random stall bursts while stalls are enabled
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic note_miss(input string what, input t_out_item want, input t_out_item got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s: want sum %0d rain %0d err %0b, got sum %0d rain %0d err %0b",
                     $time, what, want.bin_sum, want.rainfall_um, want.window_error,
                     got.bin_sum, got.rainfall_um, got.window_error);
    endtask

    // Compare each result beat with the oldest expected one
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (query_results_q.size() == 0) begin
                note_miss("result with none expected", '0, out_data);
            end else begin
                oldest_want = query_results_q.pop_front();
                if (out_data.bin_sum !== oldest_want.bin_sum ||
                    out_data.rainfall_um !== oldest_want.rainfall_um ||
                    out_data.window_error !== oldest_want.window_error)
                    note_miss("query result mismatch", oldest_want, out_data);
            end
        end
    end

    // Watchdog: cycles without any beat on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("** rain_gauge_window_accumulator: FAILED **");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        // directed checks at reset register values (prescale 1, 200 um per tip)
        dir_rows = '{
            dir_row(CMD_QUERY, 0, 1'b1, 0, 0, 1'b0),
            dir_row(CMD_QUERY, BIN_COUNT, 1'b1, 0, 0, 1'b0),
            dir_row(CMD_QUERY, BIN_COUNT + 1, 1'b1, 0, 0, 1'b1),
            dir_row(CMD_QUERY, 511, 1'b1, 0, 0, 1'b1),
            dir_row(CMD_PULSE, 511),
            dir_row(CMD_PULSE, 0),
            dir_row(CMD_QUERY, 1, 1'b1, 2, 400, 1'b0),
            dir_row(CMD_TICK, BIN_COUNT),
            dir_row(CMD_PULSE, 0),
            dir_row(CMD_QUERY, 2, 1'b1, 3, 600, 1'b0),
            dir_row(CMD_QUERY, 1, 1'b1, 1, 200, 1'b0),
            dir_row(CMD_TICK, 0),
            dir_row(CMD_TICK, 0),
            dir_row(CMD_QUERY, 3),
            dir_row(CMD_QUERY, BIN_COUNT + 1, 1'b1, 0, 0, 1'b1),
            dir_row(CMD_CLEAR, 170),
            dir_row(CMD_QUERY, BIN_COUNT, 1'b1, 0, 0, 1'b0),
            dir_row(CMD_PULSE, 0),
            dir_row(CMD_TICK, 0),
            dir_row(CMD_PULSE, 0),
            dir_row(CMD_PULSE, 0),
            dir_row(CMD_QUERY, BIN_COUNT),
            dir_row(CMD_QUERY, 2),
            dir_row(CMD_QUERY, 0, 1'b1, 0, 0, 1'b0)
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_cmd(dir_rows[r].item, dir_rows[r].pinned, dir_rows[r].want);

        // register settings, extremes among them; state carries across phases
        run_random(16'd5, 16'd1000, 200, 1'b1);
        run_random(16'd0, 16'hFFFF, 200, 1'b1);
        run_random(16'd40, 16'd3, 200, 1'b0);
        run_random(16'd3, 16'd0, 200, 1'b1);
        run_saturation();
        run_random(16'hFFFF, 16'hFFFF, 200, 1'b1);
        run_random(16'd1, 16'hFFFF, 200, 1'b1);
        run_random(16'd2, 16'd200, 200, 1'b0);

        drain_and_settle();
        if (err_cnt == 0)
            $display("** rain_gauge_window_accumulator: PASSED **");
        else
            $display("** rain_gauge_window_accumulator: FAILED **");
        $finish;
    end

endmodule
